FILE: design/fss_pkg.sv
// Shared types, constants and command codes of the frame statistics core.
`default_nettype none
package fss_pkg;

  localparam int unsigned MAX_LENGTH = 4096;
  localparam int CNT_W      = 13;
  localparam int SUM_W      = 29;
  localparam int SQ_W       = 43;
  localparam int REF_W      = 24;
  localparam int DIV_W      = 64;
  localparam int DIV_STEPS  = 64;
  localparam int DIV_CNT_W  = 7;
  localparam int RAD_W      = 48;
  localparam int ROOT_W     = 24;
  localparam int SQRT_STEPS = 24;
  localparam int SQRT_CNT_W = 5;

  localparam logic signed [15:0] SAMPLE_MOST_POS = 16'sh7fff;
  localparam logic signed [15:0] SAMPLE_MOST_NEG = 16'sh8000;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] mean_value;
    logic [39:0]        variance_value;
    logic [23:0]        deviation_value;
    logic [23:0]        rms_value;
    logic signed [15:0] min_value;
    logic signed [15:0] max_value;
    logic [42:0]        energy_value;
    logic [38:0]        power_value;
    logic [12:0]        sample_count;
    logic               overflow_flag;
  } out_item_t;

  typedef enum logic [2:0] {
    MUL_NONE    = 3'd0,
    MUL_SQHI_N  = 3'd1,
    MUL_SQLO_N  = 3'd2,
    MUL_SUM_SUM = 3'd3,
    MUL_REF_N   = 3'd4,
    MUL_ACC_REF = 3'd5
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD      = 3'd0,
    ACC_LOAD_P21  = 3'd1,
    ACC_ADD_P     = 3'd2,
    ACC_SUB_P     = 3'd3,
    ACC_P_SUB_SUM = 3'd4,
    ACC_SQ_ADD_P  = 3'd5,
    ACC_LOAD_Q    = 3'd6
  } acc_op_t;

  typedef enum logic [2:0] {
    DSRC_MEAN    = 3'd0,
    DSRC_POW     = 3'd1,
    DSRC_ACC_SHL = 3'd2,
    DSRC_ACC     = 3'd3,
    DSRC_ACC_SHR = 3'd4
  } div_src_t;

  typedef enum logic [1:0] {
    DCAP_NONE = 2'd0,
    DCAP_MEAN = 2'd1,
    DCAP_POW  = 2'd2,
    DCAP_VAR  = 2'd3
  } div_cap_t;

  typedef enum logic {
    SSRC_RMS = 1'b0,
    SSRC_DEV = 1'b1
  } sq_src_t;

  typedef enum logic [1:0] {
    SCAP_NONE = 2'd0,
    SCAP_RMS  = 2'd1,
    SCAP_DEV  = 2'd2
  } sq_cap_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     div_go;
    div_src_t div_src;
    div_cap_t div_cap;
    logic     sq_go;
    sq_src_t  sq_src;
    sq_cap_t  sq_cap;
    logic     out_load;
  } fss_cmd_t;

  typedef struct packed {
    logic ref_zero;
    logic div_done;
    logic sq_done;
  } fss_stat_t;

endpackage
`default_nettype wire

FILE: design/fss_div.sv
// Restoring divider: one quotient bit per cycle, wide dividend by sample count.
`default_nettype none
module fss_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [fss_pkg::DIV_W-1:0]     dividend,
  input  wire logic [fss_pkg::CNT_W-1:0]     divisor,
  output logic                               done,
  output logic [fss_pkg::DIV_W-1:0]          quotient
);

  logic [fss_pkg::DIV_W-1:0]     quo_r;
  logic [fss_pkg::CNT_W-1:0]     rem_r;
  logic [fss_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          done_r;
  logic [fss_pkg::CNT_W:0]       rem_sh;
  logic                          ge;
  logic [fss_pkg::CNT_W:0]       rem_nxt;

  assign rem_sh  = {rem_r, quo_r[fss_pkg::DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign rem_nxt = ge ? (rem_sh - {1'b0, divisor}) : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= fss_pkg::DIV_CNT_W'(fss_pkg::DIV_STEPS);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == fss_pkg::DIV_CNT_W'(1)) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[fss_pkg::DIV_W-2:0], ge};
      rem_r <= rem_nxt[fss_pkg::CNT_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

FILE: design/fss_sqrt.sv
// Integer square root: one root bit per cycle, two radicand bits per step.
`default_nettype none
module fss_sqrt (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [fss_pkg::RAD_W-1:0]      radicand,
  output logic                                done,
  output logic [fss_pkg::ROOT_W-1:0]          root
);

  logic [fss_pkg::RAD_W-1:0]      rad_r;
  logic [fss_pkg::ROOT_W+1:0]     rem_r;
  logic [fss_pkg::ROOT_W-1:0]     root_r;
  logic [fss_pkg::SQRT_CNT_W-1:0] cnt_r;
  logic                           done_r;
  logic [fss_pkg::ROOT_W+3:0]     rem_sh;
  logic [fss_pkg::ROOT_W+3:0]     trial;
  logic                           ge;
  logic [fss_pkg::ROOT_W+3:0]     rem_nxt;

  assign rem_sh  = {rem_r, rad_r[fss_pkg::RAD_W-1 -: 2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_nxt = ge ? (rem_sh - trial) : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= fss_pkg::SQRT_CNT_W'(fss_pkg::SQRT_STEPS);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == fss_pkg::SQRT_CNT_W'(1)) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cnt_r != '0) begin
      rad_r  <= {rad_r[fss_pkg::RAD_W-3:0], 2'b00};
      rem_r  <= rem_nxt[fss_pkg::ROOT_W+1:0];
      root_r <= {root_r[fss_pkg::ROOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

FILE: design/fss_dp.sv
// Datapath: sample accumulators, frame snapshot, multiplier, divider, root unit, result register.
`default_nettype none
module fss_dp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_fire,
  input  wire fss_pkg::in_item_t          in_data,
  input  wire logic                       cfg_we,
  input  wire logic [fss_pkg::REF_W-1:0]  cfg_wdata,
  input  wire fss_pkg::fss_cmd_t          cmd,
  output fss_pkg::fss_stat_t              stat,
  output fss_pkg::out_item_t              out_data
);

  // running frame state
  logic [fss_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [fss_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [fss_pkg::SQ_W-1:0]         sq_r, sq_nxt;
  logic signed [15:0]               min_r, min_nxt;
  logic signed [15:0]               max_r, max_nxt;
  logic                             drop_r, drop_nxt;
  logic signed [31:0]               smp_sq;
  logic                             room;

  // closed frame
  logic [fss_pkg::CNT_W-1:0]        f_cnt_r;
  logic signed [fss_pkg::SUM_W-1:0] f_sum_r;
  logic [fss_pkg::SQ_W-1:0]         f_sq_r;
  logic signed [15:0]               f_min_r;
  logic signed [15:0]               f_max_r;
  logic                             f_drop_r;

  logic signed [fss_pkg::REF_W-1:0] ref_r;

  logic signed [39:0]               mul_a;
  logic signed [29:0]               mul_b;
  logic signed [69:0]               mul_full;
  logic signed [63:0]               prod_r;
  logic signed [63:0]               acc_r;
  logic signed [63:0]               sum_ext;

  logic                             sum_neg;
  logic signed [fss_pkg::SUM_W-1:0] sum_abs;
  logic [fss_pkg::DIV_W-1:0]        div_a;
  logic                             div_done;
  logic [fss_pkg::DIV_W-1:0]        div_q;
  logic [fss_pkg::RAD_W-1:0]        sq_rad;
  logic                             sq_done;
  logic [fss_pkg::ROOT_W-1:0]       sq_root;

  logic signed [23:0]               mean_r;
  logic [46:0]                      pow_r;
  logic [39:0]                      var_r;
  logic [23:0]                      rms_r;
  logic [23:0]                      dev_r;
  fss_pkg::out_item_t               out_r;

  assign smp_sq = in_data.sample * in_data.sample;
  assign room   = cnt_r < fss_pkg::CNT_W'(fss_pkg::MAX_LENGTH);

  always_comb begin
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    sq_nxt   = sq_r;
    min_nxt  = min_r;
    max_nxt  = max_r;
    drop_nxt = drop_r;
    if (room) begin
      cnt_nxt = cnt_r + 1'b1;
      sum_nxt = sum_r + fss_pkg::SUM_W'(in_data.sample);
      sq_nxt  = sq_r + fss_pkg::SQ_W'($unsigned(smp_sq));
      if (in_data.sample < min_r) begin
        min_nxt = in_data.sample;
      end
      if (in_data.sample > max_r) begin
        max_nxt = in_data.sample;
      end
    end else begin
      drop_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      sum_r  <= '0;
      sq_r   <= '0;
      min_r  <= fss_pkg::SAMPLE_MOST_POS;
      max_r  <= fss_pkg::SAMPLE_MOST_NEG;
      drop_r <= 1'b0;
    end else if (in_fire) begin
      if (in_data.last) begin
        cnt_r  <= '0;
        sum_r  <= '0;
        sq_r   <= '0;
        min_r  <= fss_pkg::SAMPLE_MOST_POS;
        max_r  <= fss_pkg::SAMPLE_MOST_NEG;
        drop_r <= 1'b0;
      end else begin
        cnt_r  <= cnt_nxt;
        sum_r  <= sum_nxt;
        sq_r   <= sq_nxt;
        min_r  <= min_nxt;
        max_r  <= max_nxt;
        drop_r <= drop_nxt;
      end
    end
  end

  // hold the closed frame for the result engine
  always_ff @(posedge clk) begin
    if (in_fire && in_data.last) begin
      f_cnt_r  <= cnt_nxt;
      f_sum_r  <= sum_nxt;
      f_sq_r   <= sq_nxt;
      f_min_r  <= min_nxt;
      f_max_r  <= max_nxt;
      f_drop_r <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= '0;
    end else if (cfg_we) begin
      ref_r <= cfg_wdata;
    end
  end

  assign stat.ref_zero = (ref_r == '0);

  // shared multiplier, product registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      fss_pkg::MUL_SQHI_N: begin
        mul_a = signed'(40'(f_sq_r[42:21]));
        mul_b = signed'(30'(f_cnt_r));
      end
      fss_pkg::MUL_SQLO_N: begin
        mul_a = signed'(40'(f_sq_r[20:0]));
        mul_b = signed'(30'(f_cnt_r));
      end
      fss_pkg::MUL_SUM_SUM: begin
        mul_a = 40'(f_sum_r);
        mul_b = 30'(f_sum_r);
      end
      fss_pkg::MUL_REF_N: begin
        mul_a = 40'(ref_r);
        mul_b = signed'(30'(f_cnt_r));
      end
      fss_pkg::MUL_ACC_REF: begin
        mul_a = acc_r[39:0];
        mul_b = 30'(ref_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_sel != fss_pkg::MUL_NONE) begin
      prod_r <= mul_full[63:0];
    end
  end

  assign sum_ext = 64'(f_sum_r);

  always_ff @(posedge clk) begin
    case (cmd.acc_op)
      fss_pkg::ACC_LOAD_P21:  acc_r <= prod_r <<< 21;
      fss_pkg::ACC_ADD_P:     acc_r <= acc_r + prod_r;
      fss_pkg::ACC_SUB_P:     acc_r <= acc_r - prod_r;
      fss_pkg::ACC_P_SUB_SUM: acc_r <= prod_r - (sum_ext <<< 9);
      fss_pkg::ACC_SQ_ADD_P:  acc_r <= signed'({5'd0, f_sq_r, 16'd0}) + prod_r;
      fss_pkg::ACC_LOAD_Q:    acc_r <= signed'(div_q);
      default:                acc_r <= acc_r;
    endcase
  end

  assign sum_neg = f_sum_r[fss_pkg::SUM_W-1];
  assign sum_abs = sum_neg ? -f_sum_r : f_sum_r;

  always_comb begin
    case (cmd.div_src)
      fss_pkg::DSRC_MEAN:    div_a = {28'd0, sum_abs[27:0], 8'd0};
      fss_pkg::DSRC_POW:     div_a = {5'd0, f_sq_r, 16'd0};
      fss_pkg::DSRC_ACC_SHL: div_a = {acc_r[55:0], 8'd0};
      fss_pkg::DSRC_ACC:     div_a = acc_r;
      fss_pkg::DSRC_ACC_SHR: div_a = {8'd0, acc_r[63:8]};
      default:               div_a = '0;
    endcase
  end

  fss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (div_a),
    .divisor  (f_cnt_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign sq_rad = (cmd.sq_src == fss_pkg::SSRC_DEV) ? {var_r, 8'd0} : {1'b0, pow_r};

  fss_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sq_go),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign stat.div_done = div_done;
  assign stat.sq_done  = sq_done;

  always_ff @(posedge clk) begin
    case (cmd.div_cap)
      fss_pkg::DCAP_MEAN: mean_r <= sum_neg ? (24'd0 - div_q[23:0]) : div_q[23:0];
      fss_pkg::DCAP_POW:  pow_r  <= div_q[46:0];
      // saturate the variance
      fss_pkg::DCAP_VAR:  var_r  <= (|div_q[63:40]) ? '1 : div_q[39:0];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.sq_cap)
      fss_pkg::SCAP_RMS: rms_r <= sq_root;
      fss_pkg::SCAP_DEV: dev_r <= sq_root;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.mean_value      <= mean_r;
      out_r.variance_value  <= var_r;
      out_r.deviation_value <= dev_r;
      out_r.rms_value       <= rms_r;
      out_r.min_value       <= f_min_r;
      out_r.max_value       <= f_max_r;
      out_r.energy_value    <= f_sq_r;
      out_r.power_value     <= pow_r[46:8];
      out_r.sample_count    <= f_cnt_r;
      out_r.overflow_flag   <= f_drop_r;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

FILE: design/fss_ctrl.sv
// Controller: sequences the end-of-frame arithmetic and owns the result valid.
`default_nettype none
module fss_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire fss_pkg::fss_stat_t stat,
  input  wire logic               out_stall,
  output fss_pkg::fss_cmd_t       cmd,
  output logic                    busy,
  output logic                    out_valid
);

  typedef enum logic [23:0] {
    S_IDLE    = 24'd1 << 0,
    S_MEAN_GO = 24'd1 << 1,
    S_MEAN_WT = 24'd1 << 2,
    S_POW_GO  = 24'd1 << 3,
    S_POW_WT  = 24'd1 << 4,
    S_RMS_GO  = 24'd1 << 5,
    S_RMS_WT  = 24'd1 << 6,
    S_V0      = 24'd1 << 7,
    S_V1      = 24'd1 << 8,
    S_V2      = 24'd1 << 9,
    S_V3      = 24'd1 << 10,
    S_VD1_GO  = 24'd1 << 11,
    S_VD1_WT  = 24'd1 << 12,
    S_VD2_GO  = 24'd1 << 13,
    S_VD2_WT  = 24'd1 << 14,
    S_R0      = 24'd1 << 15,
    S_R1      = 24'd1 << 16,
    S_R2      = 24'd1 << 17,
    S_R3      = 24'd1 << 18,
    S_RD_GO   = 24'd1 << 19,
    S_RD_WT   = 24'd1 << 20,
    S_DEV_GO  = 24'd1 << 21,
    S_DEV_WT  = 24'd1 << 22,
    S_FIN     = 24'd1 << 23
  } state_t;

  state_t            state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  fss_pkg::fss_cmd_t cmd_c;

  always_comb begin
    state_nxt = state_r;
    cmd_c     = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_MEAN_GO;
        end
      end
      S_MEAN_GO: begin
        cmd_c.div_go  = 1'b1;
        cmd_c.div_src = fss_pkg::DSRC_MEAN;
        state_nxt     = S_MEAN_WT;
      end
      S_MEAN_WT: begin
        if (stat.div_done) begin
          cmd_c.div_cap = fss_pkg::DCAP_MEAN;
          state_nxt     = S_POW_GO;
        end
      end
      S_POW_GO: begin
        cmd_c.div_go  = 1'b1;
        cmd_c.div_src = fss_pkg::DSRC_POW;
        state_nxt     = S_POW_WT;
      end
      S_POW_WT: begin
        if (stat.div_done) begin
          cmd_c.div_cap = fss_pkg::DCAP_POW;
          state_nxt     = S_RMS_GO;
        end
      end
      S_RMS_GO: begin
        cmd_c.sq_go  = 1'b1;
        cmd_c.sq_src = fss_pkg::SSRC_RMS;
        state_nxt    = S_RMS_WT;
      end
      S_RMS_WT: begin
        if (stat.sq_done) begin
          cmd_c.sq_cap = fss_pkg::SCAP_RMS;
          state_nxt    = stat.ref_zero ? S_V0 : S_R0;
        end
      end
      // n*S2 - S*S, with S2 split in two halves
      S_V0: begin
        cmd_c.mul_sel = fss_pkg::MUL_SQHI_N;
        state_nxt     = S_V1;
      end
      S_V1: begin
        cmd_c.acc_op  = fss_pkg::ACC_LOAD_P21;
        cmd_c.mul_sel = fss_pkg::MUL_SQLO_N;
        state_nxt     = S_V2;
      end
      S_V2: begin
        cmd_c.acc_op  = fss_pkg::ACC_ADD_P;
        cmd_c.mul_sel = fss_pkg::MUL_SUM_SUM;
        state_nxt     = S_V3;
      end
      S_V3: begin
        cmd_c.acc_op = fss_pkg::ACC_SUB_P;
        state_nxt    = S_VD1_GO;
      end
      S_VD1_GO: begin
        cmd_c.div_go  = 1'b1;
        cmd_c.div_src = fss_pkg::DSRC_ACC_SHL;
        state_nxt     = S_VD1_WT;
      end
      S_VD1_WT: begin
        if (stat.div_done) begin
          cmd_c.acc_op = fss_pkg::ACC_LOAD_Q;
          state_nxt    = S_VD2_GO;
        end
      end
      S_VD2_GO: begin
        cmd_c.div_go  = 1'b1;
        cmd_c.div_src = fss_pkg::DSRC_ACC;
        state_nxt     = S_VD2_WT;
      end
      S_VD2_WT: begin
        if (stat.div_done) begin
          cmd_c.div_cap = fss_pkg::DCAP_VAR;
          state_nxt     = S_DEV_GO;
        end
      end
      // 65536*S2 + r*(n*r - 512*S)
      S_R0: begin
        cmd_c.mul_sel = fss_pkg::MUL_REF_N;
        state_nxt     = S_R1;
      end
      S_R1: begin
        cmd_c.acc_op = fss_pkg::ACC_P_SUB_SUM;
        state_nxt    = S_R2;
      end
      S_R2: begin
        cmd_c.mul_sel = fss_pkg::MUL_ACC_REF;
        state_nxt     = S_R3;
      end
      S_R3: begin
        cmd_c.acc_op = fss_pkg::ACC_SQ_ADD_P;
        state_nxt    = S_RD_GO;
      end
      S_RD_GO: begin
        cmd_c.div_go  = 1'b1;
        cmd_c.div_src = fss_pkg::DSRC_ACC_SHR;
        state_nxt     = S_RD_WT;
      end
      S_RD_WT: begin
        if (stat.div_done) begin
          cmd_c.div_cap = fss_pkg::DCAP_VAR;
          state_nxt     = S_DEV_GO;
        end
      end
      S_DEV_GO: begin
        cmd_c.sq_go  = 1'b1;
        cmd_c.sq_src = fss_pkg::SSRC_DEV;
        state_nxt    = S_DEV_WT;
      end
      S_DEV_WT: begin
        cmd_c.sq_src = fss_pkg::SSRC_DEV;
        if (stat.sq_done) begin
          cmd_c.sq_cap = fss_pkg::SCAP_DEV;
          state_nxt    = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the result register is free
        if (!out_valid_r || !out_stall) begin
          cmd_c.out_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd_c.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cmd       = cmd_c;
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == S_IDLE)
    else $error("frame closed while results still being computed");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_c.out_load |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten before being taken");
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result raised outside the finish step");
  a_div_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_c.div_go |=> !stat.div_done)
    else $error("divider done not cleared by start");
`endif

endmodule
`default_nettype wire

FILE: design/frame_signal_statistics_core.sv
// Sequence: four divisions and two roots from the closing sample to the result (zero
// reference mean), three divisions and two roots otherwise, on the 64-step divider and 24-step root.
// Throughput: one sample request per cycle; a closing sample is stalled while the
// previous frame's results are still being worked out or wait for the result register.
// Reset: synchronous active-low rst_n clears frame state, reference mean and valid.
// Top level of the frame statistics core.
`default_nettype none
module frame_signal_statistics_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire fss_pkg::in_item_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output fss_pkg::out_item_t              out_data,
  input  wire logic                       cfg_we,
  input  wire logic [fss_pkg::REF_W-1:0]  cfg_wdata
);

  logic               busy;
  logic               in_fire;
  fss_pkg::fss_cmd_t  cmd;
  fss_pkg::fss_stat_t stat;

  assign in_stall = in_data.last & busy;
  assign in_fire  = in_valid & ~in_stall;

  fss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_fire & in_data.last),
    .stat      (stat),
    .out_stall (out_stall),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  fss_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: test/tb_frame_signal_statistics_core.sv
// Self-checking testbench of the frame statistics core with a scoreboard class.
`default_nettype none

class frame_stats_board;
  fss_pkg::out_item_t result_queue[$];
  logic signed [23:0] ref_mean;
  int unsigned        n_acc;
  longint             sum_acc;
  bit [63:0]          sq_acc;
  longint             min_acc;
  longint             max_acc;
  bit                 dropped;
  int                 errors;

  function new();
    errors   = 0;
    ref_mean = '0;
    clear();
  endfunction

  function void clear();
    n_acc   = 0;
    sum_acc = 0;
    sq_acc  = '0;
    min_acc = 32767;
    max_acc = -32768;
    dropped = 1'b0;
  endfunction

  // floor(a * 2^sh / d)
  function bit [63:0] frac_div(bit [63:0] a, bit [63:0] d, int sh);
    return ((a / d) << sh) + (((a % d) << sh) / d);
  endfunction

  function bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] root;
    bit [63:0] b;
    root = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function void note_sample(fss_pkg::in_item_t it);
    longint             x;
    longint             r;
    bit [63:0]          n, su, mag, q, var_v, mean, ru, rms, pow, dev;
    fss_pkg::out_item_t res;
    x = it.sample;
    if (n_acc < fss_pkg::MAX_LENGTH) begin
      n_acc++;
      sum_acc += x;
      sq_acc  += 64'(x * x);
      if (x < min_acc) min_acc = x;
      if (x > max_acc) max_acc = x;
    end else begin
      dropped = 1'b1;
    end
    if (!it.last) return;
    n  = n_acc;
    su = sum_acc;
    r  = ref_mean;
    mag  = (sum_acc < 0) ? -su : su;
    q    = (mag << 8) / n;
    mean = (sum_acc < 0) ? -q : q;
    if (r == 0) begin
      q = n * sq_acc - su * su;
      var_v = frac_div(q, n, 8) / n;
    end else begin
      ru = r;
      q = (sq_acc << 16) - ((su * ru) << 9) + n * ru * ru;
      var_v = (q >> 8) / n;
    end
    rms = int_sqrt(frac_div(sq_acc, n, 16));
    pow = frac_div(sq_acc, n, 8);
    if (var_v > 64'hff_ffff_ffff) var_v = 64'hff_ffff_ffff;
    dev = int_sqrt(var_v << 8);
    res.mean_value      = mean[23:0];
    res.variance_value  = var_v[39:0];
    res.deviation_value = dev[23:0];
    res.rms_value       = rms[23:0];
    res.min_value       = min_acc[15:0];
    res.max_value       = max_acc[15:0];
    res.energy_value    = sq_acc[42:0];
    res.power_value     = pow[38:0];
    res.sample_count    = n[12:0];
    res.overflow_flag   = dropped;
    result_queue.push_back(res);
    clear();
  endfunction

  function void check_result(fss_pkg::out_item_t got);
    fss_pkg::out_item_t exp_r;
    if (result_queue.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp_r = result_queue.pop_front();
    if (got.mean_value !== exp_r.mean_value) begin
      $display("%0t: mean exp %0d got %0d", $time, exp_r.mean_value, got.mean_value);
      errors++;
    end
    if (got.variance_value !== exp_r.variance_value) begin
      $display("%0t: variance exp %0d got %0d", $time, exp_r.variance_value,
               got.variance_value);
      errors++;
    end
    if (got.deviation_value !== exp_r.deviation_value) begin
      $display("%0t: deviation exp %0d got %0d", $time, exp_r.deviation_value,
               got.deviation_value);
      errors++;
    end
    if (got.rms_value !== exp_r.rms_value) begin
      $display("%0t: rms exp %0d got %0d", $time, exp_r.rms_value, got.rms_value);
      errors++;
    end
    if (got.min_value !== exp_r.min_value) begin
      $display("%0t: min exp %0d got %0d", $time, exp_r.min_value, got.min_value);
      errors++;
    end
    if (got.max_value !== exp_r.max_value) begin
      $display("%0t: max exp %0d got %0d", $time, exp_r.max_value, got.max_value);
      errors++;
    end
    if (got.energy_value !== exp_r.energy_value) begin
      $display("%0t: energy exp %0d got %0d", $time, exp_r.energy_value, got.energy_value);
      errors++;
    end
    if (got.power_value !== exp_r.power_value) begin
      $display("%0t: power exp %0d got %0d", $time, exp_r.power_value, got.power_value);
      errors++;
    end
    if (got.sample_count !== exp_r.sample_count) begin
      $display("%0t: count exp %0d got %0d", $time, exp_r.sample_count, got.sample_count);
      errors++;
    end
    if (got.overflow_flag !== exp_r.overflow_flag) begin
      $display("%0t: overflow exp %0d got %0d", $time, exp_r.overflow_flag,
               got.overflow_flag);
      errors++;
    end
  endfunction
endclass

module tb_frame_signal_statistics_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  fss_pkg::in_item_t         in_data = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  fss_pkg::out_item_t        out_data;
  logic                      cfg_we = 1'b0;
  logic [fss_pkg::REF_W-1:0] cfg_wdata = '0;

  frame_stats_board stats_board;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      hold_cycles = 0;
  int unsigned      items_sent = 0;

  frame_signal_statistics_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // receiver: long hold-off when asked, random stalls otherwise
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) stats_board.check_result(out_data);
  end

  task automatic send_sample(logic signed [15:0] s, logic l);
    in_valid = 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    in_data.sample = s;
    in_data.last = l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    stats_board.note_sample(in_data);
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_frame(int unsigned len);
    for (int unsigned i = 1; i <= len; i++) send_sample(pick_sample(), i == len);
  endtask

  // drain the block, then wait out the last result's tail before a write
  task automatic write_ref(logic [23:0] v);
    while (stats_board.result_queue.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    stats_board.ref_mean = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    #60_000_000;
    $display("frame_signal_statistics_core regression: fail");
    $finish;
  end

  initial begin
    logic [23:0] ref_list[5];
    int unsigned budget;
    stats_board = new();
    ref_list = '{24'h000000, 24'h800000, 24'h7fff00, 24'h000100, 24'h000000};
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    // directed frames
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0000, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b1);
    repeat (4) send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(-16'sd3, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shaaaa, 1'b1);
    for (int p = 0; p < 5; p++) begin
      write_ref(p == 4 ? 24'($urandom_range(1, 24'hffffff)) : ref_list[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      if (p == 2) begin
        send_idle_pct = 0;
        hold_cycles = 3000;
      end
      if (p == 1) send_frame(fss_pkg::MAX_LENGTH + 4);
      budget = items_sent + 240;
      while (items_sent < budget) begin
        if ($urandom_range(0, 9) == 0) send_frame($urandom_range(20, 60));
        else send_frame($urandom_range(1, 12));
      end
    end
    while (stats_board.result_queue.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (stats_board.errors == 0) begin
      $display("frame_signal_statistics_core regression: pass");
    end else begin
      $display("frame_signal_statistics_core regression: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire
